@@ design/muv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muv_pkg
// Shared types and constants for the modified UTF-8 string checker.
// ----------------------------------------------------------------------------
package muv_pkg;

   // byte class produced by the front end
   typedef enum logic [2:0] {
      KIND_ZERO  = 3'd0,
      KIND_ASCII = 3'd1,
      KIND_LEAD2 = 3'd2,
      KIND_LEAD3 = 3'd3,
      KIND_CONT  = 3'd4,
      KIND_BAD   = 3'd5
   } muv_kind_type;

   // classified word passed through the queue
   typedef struct packed {
      muv_kind_type kind;
      logic [5:0]   bits;
   } muv_item_type;

   localparam int unsigned ItemWidth = $bits(muv_item_type);

   localparam logic [7:0]  ContMask    = 8'hC0;
   localparam logic [7:0]  ContCode    = 8'h80;
   localparam logic [7:0]  Lead2Mask   = 8'hE0;
   localparam logic [7:0]  Lead2Code   = 8'hC0;
   localparam logic [7:0]  Lead3Mask   = 8'hF0;
   localparam logic [7:0]  Lead3Code   = 8'hE0;

   localparam logic [10:0] TwoMin      = 11'h080;
   localparam logic [15:0] ThreeMin    = 16'h0800;
   localparam logic [15:0] HighSurMin  = 16'hD800;
   localparam logic [15:0] LowSurMin   = 16'hDC00;
   localparam logic [15:0] LowSurMax   = 16'hDFFF;

endpackage : muv_pkg
`default_nettype wire

@@ design/muv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muv_front
// Accepts string bytes and classifies each one into a word for the queue.
// ----------------------------------------------------------------------------
module muv_front (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   output logic                      push,
   output muv_pkg::muv_item_type     push_item,
   input  wire logic                 q_full
);
   import muv_pkg::*;

   muv_kind_type kind;

   always_comb begin
      if (req_data_byte == 8'h00) begin
         kind = KIND_ZERO;
      end else if (!req_data_byte[7]) begin
         kind = KIND_ASCII;
      end else if ((req_data_byte & ContMask) == ContCode) begin
         kind = KIND_CONT;
      end else if ((req_data_byte & Lead2Mask) == Lead2Code) begin
         kind = KIND_LEAD2;
      end else if ((req_data_byte & Lead3Mask) == Lead3Code) begin
         kind = KIND_LEAD3;
      end else begin
         kind = KIND_BAD;
      end
   end

   assign req_ready      = !q_full;
   assign push           = req_valid && !q_full;
   assign push_item.kind = kind;
   assign push_item.bits = req_data_byte[5:0];

endmodule : muv_front
`default_nettype wire

@@ design/muv_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muv_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module muv_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire muv_pkg::muv_item_type push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      q_valid,
   output muv_pkg::muv_item_type     q_item
);
   import muv_pkg::*;

   muv_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : muv_queue
`default_nettype wire

@@ design/muv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muv_back
// Sequence checker: walks the classified words and issues one verdict word
// per terminating zero.
// ----------------------------------------------------------------------------
module muv_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire muv_pkg::muv_item_type q_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_string_valid
);
   import muv_pkg::*;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_TWO_C1   = 7'b0000010,
      PH_THREE_C1 = 7'b0000100,
      PH_THREE_C2 = 7'b0001000,
      PH_LOW_LEAD = 7'b0010000,
      PH_LOW_C1   = 7'b0100000,
      PH_LOW_C2   = 7'b1000000
   } muv_phase_type;

   muv_phase_type phase_ff, phase_in;
   logic [9:0]    part_ff, part_in;
   logic          err_ff, err_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_sv_ff, out_sv_in;

   logic          out_free;
   logic          is_cont;
   logic          fail;
   logic [10:0]   cp2;
   logic [15:0]   cp3;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = q_valid && ((q_item.kind != KIND_ZERO) || out_free);
   assign is_cont  = (q_item.kind == KIND_CONT);
   assign cp2      = {part_ff[4:0], q_item.bits};
   assign cp3      = {part_ff, q_item.bits};

   assign rsp_valid        = out_valid_ff;
   assign rsp_string_valid = out_sv_ff;

   always_comb begin
      phase_in     = phase_ff;
      part_in      = part_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_sv_in    = out_sv_ff;
      fail         = 1'b0;

      if (pop) begin
         if (q_item.kind == KIND_ZERO) begin
            out_valid_in = 1'b1;
            out_sv_in    = !err_ff && (phase_ff == PH_IDLE);
            phase_in     = PH_IDLE;
            part_in      = '0;
            err_in       = 1'b0;
         end else if (!err_ff) begin
            case (phase_ff)
               PH_IDLE: begin
                  case (q_item.kind)
                     KIND_ASCII: ;
                     KIND_LEAD2: begin
                        part_in  = {5'd0, q_item.bits[4:0]};
                        phase_in = PH_TWO_C1;
                     end
                     KIND_LEAD3: begin
                        part_in  = {6'd0, q_item.bits[3:0]};
                        phase_in = PH_THREE_C1;
                     end
                     default: fail = 1'b1;
                  endcase
               end
               PH_TWO_C1: begin
                  // C0 80 is the encoded zero; anything else below 0x80 is overlong
                  if (!is_cont || (cp2 != 11'd0 && cp2 < TwoMin)) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_IDLE;
                     part_in  = '0;
                  end
               end
               PH_THREE_C1, PH_LOW_C1: begin
                  if (!is_cont) begin
                     fail = 1'b1;
                  end else begin
                     part_in  = {part_ff[3:0], q_item.bits};
                     phase_in = (phase_ff == PH_THREE_C1) ? PH_THREE_C2 : PH_LOW_C2;
                  end
               end
               PH_THREE_C2: begin
                  if (!is_cont || cp3 < ThreeMin || cp3 >= LowSurMin) begin
                     // low surrogate range is above 0xDBFF and up to 0xDFFF
                     if (!is_cont || cp3 < ThreeMin || cp3 <= LowSurMax) begin
                        fail = 1'b1;
                     end else begin
                        phase_in = PH_IDLE;
                        part_in  = '0;
                     end
                  end else begin
                     part_in  = '0;
                     phase_in = (cp3 >= HighSurMin) ? PH_LOW_LEAD : PH_IDLE;
                  end
               end
               PH_LOW_LEAD: begin
                  if (q_item.kind != KIND_LEAD3) begin
                     fail = 1'b1;
                  end else begin
                     part_in  = {6'd0, q_item.bits[3:0]};
                     phase_in = PH_LOW_C1;
                  end
               end
               PH_LOW_C2: begin
                  if (!is_cont || cp3 < LowSurMin || cp3 > LowSurMax) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_IDLE;
                     part_in  = '0;
                  end
               end
               default: fail = 1'b1;
            endcase
            if (fail) begin
               err_in   = 1'b1;
               phase_in = PH_IDLE;
               part_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         part_ff      <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         part_ff      <= part_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sv_ff <= out_sv_in;
   end

endmodule : muv_back
`default_nettype wire

@@ design/modified_utf8_validator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modified_utf8_validator
// Checks zero-terminated byte strings as Java modified UTF-8.
// ----------------------------------------------------------------------------
//   channel | ports                               | carries
//   --------+-------------------------------------+---------------------------
//   req     | req_valid, req_ready, req_data_byte | one string byte per word
//   rsp     | rsp_valid, rsp_ready, rsp_string_valid | verdict, one per zero byte
//
// One byte per cycle sustained. A byte is classified on entry and lands in a
// two-entry queue; the sequence checker drains one word per cycle. A zero byte
// passes a queue slot and then the verdict register before it is presented.
// The checker stalls only on a zero byte whose verdict register is still
// occupied; nonzero bytes keep draining. Once the queue has filled, the input
// takes a one-cycle gap as it starts to drain. Reset (synchronous) empties the
// queue and clears checker state; the verdict bit and queue slots keep theirs.
// ----------------------------------------------------------------------------
module modified_utf8_validator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_string_valid
);
   import muv_pkg::*;

   logic         push;
   muv_item_type push_item;
   logic         q_full;
   logic         pop;
   logic         q_valid;
   muv_item_type q_item;

   muv_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_item     (push_item),
      .q_full        (q_full)
   );

   muv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   muv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid)
   );

endmodule : modified_utf8_validator
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modified UTF-8 string checker. Byte strings go
// in one word per handshake; an in-bench model of the sequence checker
// predicts the verdict for every zero byte and the monitor compares each
// verdict word in order. Directed strings cover the code point limits,
// surrogate pairs and error paths. Random strings follow: mostly
// well-formed characters, some corrupted, plus raw noise. Both sides stall
// at random, except for one stretch that runs back to back.
// ----------------------------------------------------------------------------
module tb_top;
   import muv_pkg::*;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned IdlePct     = 22;
   localparam int unsigned DrainCycles = 10;

   typedef enum logic [2:0] {
      SEQ_IDLE      = 3'd0,
      SEQ_TWO_C1    = 3'd1,
      SEQ_THREE_C1  = 3'd2,
      SEQ_THREE_C2  = 3'd3,
      SEQ_LOW_LEAD  = 3'd4,
      SEQ_LOW_C1    = 3'd5,
      SEQ_LOW_C2    = 3'd6
   } seq_phase_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic       rsp_string_valid;

   // model of the sequence checker
   seq_phase_type model_phase   = SEQ_IDLE;
   logic [15:0]   model_partial = 16'h0000;
   logic          model_error   = 1'b0;

   logic        verdict_q[$];
   logic [7:0]  string_buf[$];
   bit          no_idle = 1'b0;

   int unsigned error_count    = 0;
   int unsigned bytes_sent     = 0;
   int unsigned strings_sent   = 0;
   int unsigned verdicts_seen  = 0;
   int unsigned verdicts_valid = 0;
   int unsigned cycle_count    = 0;

   modified_utf8_validator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("tb_top: MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void model_clear();
      model_phase   = SEQ_IDLE;
      model_partial = 16'h0000;
      model_error   = 1'b0;
   endfunction

   function automatic void model_fail();
      model_error   = 1'b1;
      model_phase   = SEQ_IDLE;
      model_partial = 16'h0000;
   endfunction

   // advance the model by one accepted byte; a zero byte queues a verdict
   function automatic void model_advance(input logic [7:0] b);
      logic [21:0] raw;
      logic [15:0] cp;
      logic        cont;
      raw  = {model_partial, b[5:0]};
      cp   = raw[15:0];
      cont = (b & ContMask) == ContCode;
      if (b == 8'h00) begin
         verdict_q.push_back(!model_error && model_phase == SEQ_IDLE);
         model_clear();
      end else if (!model_error) begin
         case (model_phase)
            SEQ_IDLE: begin
               if (!b[7]) begin
                  // plain ASCII, nothing to track
               end else if ((b & Lead2Mask) == Lead2Code) begin
                  model_partial = {11'h000, b[4:0]};
                  model_phase   = SEQ_TWO_C1;
               end else if ((b & Lead3Mask) == Lead3Code) begin
                  model_partial = {12'h000, b[3:0]};
                  model_phase   = SEQ_THREE_C1;
               end else begin
                  model_fail();
               end
            end
            SEQ_TWO_C1: begin
               // zero code point is only legal as the encoded zero C0 80
               if (!cont || (cp != 16'h0000 && (cp < 16'(TwoMin) || cp > 16'h07FF)))
                  model_fail();
               else begin
                  model_phase   = SEQ_IDLE;
                  model_partial = 16'h0000;
               end
            end
            SEQ_THREE_C1, SEQ_LOW_C1: begin
               if (!cont)
                  model_fail();
               else begin
                  model_partial = cp;
                  model_phase   = (model_phase == SEQ_THREE_C1) ? SEQ_THREE_C2 : SEQ_LOW_C2;
               end
            end
            SEQ_THREE_C2: begin
               if (!cont || cp < ThreeMin || (cp >= LowSurMin && cp <= LowSurMax))
                  model_fail();
               else begin
                  model_partial = 16'h0000;
                  model_phase   = (cp >= HighSurMin && cp < LowSurMin) ? SEQ_LOW_LEAD : SEQ_IDLE;
               end
            end
            SEQ_LOW_LEAD: begin
               if ((b & Lead3Mask) != Lead3Code)
                  model_fail();
               else begin
                  model_partial = {12'h000, b[3:0]};
                  model_phase   = SEQ_LOW_C1;
               end
            end
            SEQ_LOW_C2: begin
               if (!cont || cp < LowSurMin || cp > LowSurMax)
                  model_fail();
               else begin
                  model_phase   = SEQ_IDLE;
                  model_partial = 16'h0000;
               end
            end
            default: model_fail();
         endcase
      end
   endfunction

   // monitor and random back-pressure on the verdict channel
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (verdict_q.size() == 0)
            report_mismatch("verdict word with nothing expected");
         else begin
            want = verdict_q.pop_front();
            if (want)
               verdicts_valid++;
            if (rsp_string_valid !== want)
               report_mismatch($sformatf("string_valid got %b want %b",
                                         rsp_string_valid, want));
         end
      end
      rsp_ready <= no_idle || ($urandom_range(99, 0) >= IdlePct);
   end

   // hold the word until accepted; idle only before raising valid
   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(99, 0) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      model_advance(b);
      bytes_sent++;
   endtask

   task automatic send_string();
      foreach (string_buf[i])
         send_byte(string_buf[i]);
      send_byte(8'h00);
      strings_sent++;
      string_buf.delete();
   endtask

   function automatic void push_codepoint(input logic [15:0] cp);
      if (cp == 16'h0000) begin
         string_buf.push_back(8'hC0);
         string_buf.push_back(8'h80);
      end else if (cp < 16'h0080) begin
         string_buf.push_back(cp[7:0]);
      end else if (cp < 16'h0800) begin
         string_buf.push_back({3'b110, cp[10:6]});
         string_buf.push_back({2'b10, cp[5:0]});
      end else begin
         string_buf.push_back({4'b1110, cp[15:12]});
         string_buf.push_back({2'b10, cp[11:6]});
         string_buf.push_back({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void push_random_char();
      int unsigned sel;
      logic [15:0] cp;
      sel = $urandom_range(9, 0);
      case (sel)
         0, 1, 2, 3: push_codepoint(16'($urandom_range(127, 1)));
         4:          push_codepoint(16'h0000);
         5, 6:       push_codepoint(16'($urandom_range(16'h07FF, 16'h0080)));
         7, 8: begin
            cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            // steer clear of the surrogate range
            if (cp[15:11] == 5'b11011)
               cp[14] = 1'b0;
            push_codepoint(cp);
         end
         default: begin
            push_codepoint(16'($urandom_range(16'hDBFF, 16'hD800)));
            push_codepoint(16'($urandom_range(16'hDFFF, 16'hDC00)));
         end
      endcase
   endfunction

   task automatic test_ascii();
      string_buf.delete();
      send_string();
      string_buf = '{8'h01, 8'h41, 8'h7F};
      send_string();
   endtask

   task automatic test_two_byte();
      string_buf = '{8'hC0, 8'h80};
      send_string();
      string_buf = '{8'hC2, 8'h80, 8'hDF, 8'hBF};
      send_string();
      // overlong forms
      string_buf = '{8'hC1, 8'hBF};
      send_string();
      string_buf = '{8'hC0, 8'h81};
      send_string();
   endtask

   task automatic test_three_byte();
      string_buf = '{8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF};
      send_string();
      string_buf = '{8'hE0, 8'h9F, 8'hBF};
      send_string();
   endtask

   task automatic test_surrogates();
      string_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hBF, 8'hBF};
      send_string();
      // lone low surrogate
      string_buf = '{8'hED, 8'hB0, 8'h80};
      send_string();
      // high surrogate without a low one
      string_buf = '{8'hED, 8'hAF, 8'hBF, 8'h41};
      send_string();
      string_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80};
      send_string();
      // bad continuation inside the low surrogate
      string_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'h41};
      send_string();
      string_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'hC0};
      send_string();
   endtask

   task automatic test_bad_bytes();
      string_buf = '{8'hF0};
      send_string();
      string_buf = '{8'hFF};
      send_string();
      string_buf = '{8'h80};
      send_string();
      string_buf = '{8'hC2, 8'h41};
      send_string();
   endtask

   task automatic test_zero_in_sequence();
      string_buf = '{8'hC2};
      send_string();
      string_buf = '{8'hE1, 8'h80};
      send_string();
      string_buf = '{8'hED, 8'hA0, 8'h80};
      send_string();
      string_buf = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0};
      send_string();
   endtask

   task automatic test_error_absorb();
      string_buf = '{8'h80, 8'hC2, 8'h80, 8'h41};
      send_string();
      string_buf = '{8'h41};
      send_string();
   endtask

   // well-formed strings, a share of them broken after the fact
   task automatic test_random_strings(input int unsigned byte_goal,
                                      input int unsigned corrupt_pct);
      int unsigned stop_at;
      int unsigned n;
      int unsigned idx;
      stop_at = bytes_sent + byte_goal;
      while (bytes_sent < stop_at) begin
         n = $urandom_range(6, 0);
         repeat (n) push_random_char();
         if (string_buf.size() != 0 && $urandom_range(99, 0) < corrupt_pct) begin
            idx = $urandom_range(string_buf.size() - 1, 0);
            case ($urandom_range(2, 0))
               0:       string_buf[idx] = 8'($urandom_range(255, 0));
               1:       void'(string_buf.pop_back());
               default: string_buf.push_front(8'($urandom_range(255, 128)));
            endcase
         end
         send_string();
      end
   endtask

   task automatic test_random_noise(input int unsigned byte_goal);
      int unsigned stop_at;
      int unsigned n;
      stop_at = bytes_sent + byte_goal;
      while (bytes_sent < stop_at) begin
         n = $urandom_range(6, 0);
         repeat (n) string_buf.push_back(8'($urandom_range(255, 1)));
         send_string();
      end
   endtask

   task automatic test_back_to_back(input int unsigned byte_goal);
      no_idle = 1'b1;
      test_random_strings(byte_goal, 10);
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii();
      test_two_byte();
      test_three_byte();
      test_surrogates();
      test_bad_bytes();
      test_zero_in_sequence();
      test_error_absorb();
      test_random_strings(250, 20);
      test_back_to_back(100);
      test_random_noise(100);

      req_valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("tb_top: %0d strings, %0d bytes sent", strings_sent, bytes_sent);
      $display("tb_top: %0d verdicts checked, %0d valid, %0d mismatches",
               verdicts_seen, verdicts_valid, error_count);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule : tb_top

@@ filelist.f @@
design/muv_pkg.sv
design/muv_front.sv
design/muv_queue.sv
design/muv_back.sv
design/modified_utf8_validator.sv
sim/tb_top.sv
